// ----- rtl/vecnorm_pkg.sv -----
// Shared types and constants for the vector Euclidean norm block.
// Used by vecnorm_ctrl, vecnorm_dp and the vector_euclidean_norm top level.
`timescale 1ns / 1ps

package vecnorm_pkg;

    // Element precision taken from the low bits of the sample field.
    localparam int ElemBits    = 32;
    localparam int SampleWidth = 32;
    localparam int SumWidth    = 64;
    localparam int NormWidth   = 32;
    localparam int RootIters   = SumWidth / 2;
    localparam int IterBits    = $clog2(RootIters);
    // Partial remainder of the digit-by-digit square root.
    localparam int RemWidth    = NormWidth + 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_ROOT,
        ST_DONE
    } vecnorm_state_t;

    typedef struct packed {
        logic load_in;     // capture the element magnitude and flags
        logic square;      // register the square of the magnitude
        logic accum;       // add the square into the running sum
        logic root_step;   // one iteration of the square root
        logic out_load;    // move the finished norm into the output register
    } vecnorm_cmd_t;

    typedef struct packed {
        logic last_item;   // captured item closes the vector
        logic out_free;    // output register can take a new result
    } vecnorm_status_t;

endpackage

// ----- rtl/vecnorm_dp.sv -----
// Datapath of the vector Euclidean norm: magnitude, square, saturating sum,
// iterative square root and output register. Depends on vecnorm_pkg.
`timescale 1ns / 1ps

module vecnorm_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [vecnorm_pkg::SampleWidth-1:0] sample,
    input  logic                               has_sample,
    input  logic                               last_element,
    input  vecnorm_pkg::vecnorm_cmd_t          cmd,
    output vecnorm_pkg::vecnorm_status_t       status,
    output logic [vecnorm_pkg::NormWidth-1:0]  norm,
    output logic                               saturated,
    output logic                               out_valid,
    input  logic                               out_ready
);
    import vecnorm_pkg::*;

    logic [ElemBits-1:0]   elem;
    logic [ElemBits-1:0]   mag;
    logic [ElemBits-1:0]   mag_reg;
    logic                  has_reg;
    logic                  last_reg;
    logic [2*ElemBits-1:0] prod_reg;
    logic                  prod_has_reg;

    logic [SumWidth-1:0]   sum_reg;
    logic [SumWidth-1:0]   sum_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [SumWidth:0]     sum_wide;
    logic [SumWidth-1:0]   sum_new;
    logic                  ovf_new;

    logic [SumWidth-1:0]   rad_reg;
    logic [SumWidth-1:0]   rad_next;
    logic [RemWidth-1:0]   rem_reg;
    logic [RemWidth-1:0]   rem_next;
    logic [RemWidth-1:0]   rem_sh;
    logic [RemWidth-1:0]   trial;
    logic [NormWidth-1:0]  root_reg;
    logic [NormWidth-1:0]  root_next;
    logic                  root_sat_reg;

    logic [NormWidth-1:0]  norm_reg;
    logic                  sat_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // Two's complement magnitude; the most negative value maps to 2^(ElemBits-1).
    assign elem = sample[ElemBits-1:0];
    assign mag  = elem[ElemBits-1] ? (~elem + ElemBits'(1)) : elem;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mag_reg  <= mag;
            has_reg  <= has_sample;
            last_reg <= last_element;
        end
        if (cmd.square) begin
            prod_reg     <= mag_reg * mag_reg;
            prod_has_reg <= has_reg;
        end
    end

    // Saturating accumulation; the carry out of the wide add marks overflow.
    always_comb begin
        sum_wide = {1'b0, sum_reg} + {1'b0, SumWidth'(prod_reg)};
        if (!prod_has_reg) begin
            sum_new = sum_reg;
            ovf_new = ovf_reg;
        end else if (sum_wide[SumWidth]) begin
            sum_new = {SumWidth{1'b1}};
            ovf_new = 1'b1;
        end else begin
            sum_new = sum_wide[SumWidth-1:0];
            ovf_new = ovf_reg;
        end
    end

    always_comb begin
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        if (cmd.accum) begin
            // The closing item starts a fresh vector once its sum moves to the root unit.
            sum_next = last_reg ? '0 : sum_new;
            ovf_next = last_reg ? 1'b0 : ovf_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
        end
    end

    // Digit-by-digit square root, two radicand bits per iteration.
    always_comb begin
        rem_sh    = {rem_reg[RemWidth-3:0], rad_reg[SumWidth-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        rad_next  = {rad_reg[SumWidth-3:0], 2'b00};
        if (rem_sh >= trial) begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[NormWidth-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh;
            root_next = {root_reg[NormWidth-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accum && last_reg) begin
            rad_reg      <= sum_new;
            rem_reg      <= '0;
            root_reg     <= '0;
            root_sat_reg <= ovf_new;
        end else if (cmd.root_step) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    // Output register: a waiting result does not block new elements.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            norm_reg <= root_reg;
            sat_reg  <= root_sat_reg;
        end
    end

    assign status.last_item = last_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign norm      = norm_reg;
    assign saturated = sat_reg;
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/vecnorm_ctrl.sv -----
// Controller state machine of the vector Euclidean norm block.
// Sequences the datapath through its commands; depends on vecnorm_pkg.
`timescale 1ns / 1ps

module vecnorm_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  vecnorm_pkg::vecnorm_status_t  status,
    output vecnorm_pkg::vecnorm_cmd_t     cmd
);
    import vecnorm_pkg::*;

    vecnorm_state_t      state_reg;
    vecnorm_state_t      state_next;
    logic [IterBits-1:0] iter_reg;
    logic [IterBits-1:0] iter_next;
    logic                iter_last;

    assign iter_last = (iter_reg == IterBits'(RootIters - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                state_next = status.last_item ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT: begin
                if (iter_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        iter_next = iter_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
            end
            ST_ACCUM: begin
                cmd.accum = 1'b1;
                iter_next = '0;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                iter_next     = iter_reg + IterBits'(1);
            end
            ST_DONE: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

// ----- rtl/vector_euclidean_norm.sv -----
// Usage:
// Streaming Euclidean norm of a vector of signed Q16.16 elements. Each input
// transaction on the s_ channel carries one item: the element in s_tdata, a
// flag in s_tuser that says whether the element is real, and s_tlast on the
// item that closes the vector. Squares are summed in a 64-bit Q32.32 register
// that clamps at its maximum. On the closing item one result transaction
// leaves on the m_ channel: the floor of the square root of the sum as an
// unsigned Q16.16 norm in m_tdata and the saturation flag in m_tuser.
// Each item passes through capture, square and accumulate steps on the single
// registered multiplier and adder; a new item is taken only once the control
// is back in idle. After a closing item is taken, the square and accumulate
// steps, the iterations of the two-bits-per-cycle square root unit and the
// output register load follow in order, and m_tvalid rises with that load.
// The output register holds a result while the receiver stalls and new items
// keep being accepted; only a second finished norm waits for it to drain.
// Synchronous reset clears the sum, the saturation flag and the output valid.
// Depends on vecnorm_pkg, vecnorm_ctrl and vecnorm_dp.
`timescale 1ns / 1ps

module vector_euclidean_norm (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [vecnorm_pkg::SampleWidth-1:0] s_tdata,   // [31:0] sample
    input  logic                                s_tuser,   // [0] has_sample
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [vecnorm_pkg::NormWidth-1:0]   m_tdata,   // [31:0] norm
    output logic                                m_tuser    // [0] saturated
);
    import vecnorm_pkg::*;

    vecnorm_cmd_t    cmd;
    vecnorm_status_t status;

    vecnorm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vecnorm_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sample       (s_tdata),
        .has_sample   (s_tuser),
        .last_element (s_tlast),
        .cmd          (cmd),
        .status       (status),
        .norm         (m_tdata),
        .saturated    (m_tuser),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready)
    );

endmodule

// ----- tb/vector_euclidean_norm_test.sv -----
// Self-checking testbench for vector_euclidean_norm: directed and random vectors with
// random idling on both stream channels, checked against a sum-of-squares predictor.
// Depends on vecnorm_pkg and the vector_euclidean_norm RTL.
`timescale 1ns / 1ps

module vector_euclidean_norm_test;
    import vecnorm_pkg::*;

    localparam int CycleLimit   = 400000;
    localparam int RandomItems  = 1600;
    localparam int DrainCycles  = 80;
    localparam int DirectedRows = 26;

    typedef struct packed {
        logic [SampleWidth-1:0] sample;
        logic                   has;
        logic                   is_last;
        logic                   typed;    // expected result given in the row
        logic [NormWidth-1:0]   norm;
        logic                   sat;
    } stim_row_t;

    typedef struct packed {
        logic [NormWidth-1:0] norm;
        logic                 sat;
    } norm_result_t;

    // Rows marked typed carry their norm; the others are left to the predictor.
    localparam stim_row_t DirectedTable [DirectedRows] = '{
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0001_0000, 1'b1, 1'b1, 1'b1, 32'h0001_0000, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'h0000_0001, 1'b0},
        '{32'hDEAD_BEEF, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h0000_0001, 1'b1, 1'b1, 1'b1, 32'h0000_0001, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
        '{32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h0003_0000, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'hFFFC_0000, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h5555_5555, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0005_0000, 1'b0},
        '{32'h1234_5678, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
        '{32'hA5A5_A5A5, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h5A5A_5A5A, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h8000_0001, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
        '{32'h0001_0000, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1}
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [SampleWidth-1:0] s_tdata;   // [31:0] sample
    logic                   s_tuser;   // [0] has_sample
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [NormWidth-1:0]   m_tdata;   // [31:0] norm
    logic                   m_tuser;   // [0] saturated

    norm_result_t         norms_due[$];
    logic [SumWidth-1:0]  model_sum;
    logic                 model_sat;
    int                   fail_count = 0;
    int                   cycle_count = 0;
    bit                   sender_burst;
    bit                   receiver_burst = 1'b0;

    vector_euclidean_norm dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("vector_euclidean_norm regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [NormWidth-1:0] got,
                                   input logic [NormWidth-1:0] want);
        $display("[%0t] mismatch: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Folds one item into the running sum of squares; on a closing item it
    // returns 1 with the truncated square root and the saturation flag.
    function automatic bit fold_item(input logic [SampleWidth-1:0] sample, input logic has,
                                     input logic is_last, output norm_result_t res);
        logic [63:0] field_mask;
        logic [63:0] raw;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] trial;
        logic [63:0] root;
        logic [64:0] wide;
        field_mask = (64'd1 << ElemBits) - 64'd1;
        res = '0;
        if (has) begin
            raw = {{(64 - SampleWidth){1'b0}}, sample} & field_mask;
            mag = raw[ElemBits-1] ? (64'd1 << ElemBits) - raw : raw;
            sq = mag * mag;
            wide = {1'b0, model_sum} + {1'b0, sq};
            if (wide[64]) begin
                model_sum = '1;
                model_sat = 1'b1;
            end else begin
                model_sum = wide[63:0];
            end
        end
        if (!is_last) return 1'b0;
        // Build the root one bit at a time from the top, keeping each bit
        // whose trial square still fits under the sum.
        root = '0;
        for (int i = NormWidth - 1; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= model_sum) root = trial;
        end
        res.norm = root[NormWidth-1:0];
        res.sat = model_sat;
        model_sum = '0;
        model_sat = 1'b0;
        return 1'b1;
    endfunction

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic logic [SampleWidth-1:0] draw_element(input bit heavy);
        logic [31:0] r;
        r = $urandom;
        if (heavy) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h8000_0000 | (r & 32'h0000_FFFF);
                default: return 32'h7FFF_0000 | (r & 32'h0000_FFFF);
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return r;
            4, 5, 6: begin
                r = $urandom_range(0, 32'h3FFFF);
                return $urandom_range(0, 1) ? -r : r;
            end
            7: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows the transaction.
    task automatic send_item(input stim_row_t row);
        int           gap;
        norm_result_t res;
        if ($urandom_range(0, 99) == 0) sender_burst = !sender_burst;
        gap = draw_gap(sender_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.sample;
        s_tuser  <= row.has;
        s_tlast  <= row.is_last;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        if (fold_item(row.sample, row.has, row.is_last, res)) begin
            if (row.typed) begin
                res.norm = row.norm;
                res.sat = row.sat;
            end
            norms_due.push_back(res);
        end
        @(negedge aclk);
    endtask

    task automatic send_plain(input logic [SampleWidth-1:0] sample, input logic has,
                              input logic is_last);
        stim_row_t row;
        row = '0;
        row.sample = sample;
        row.has = has;
        row.is_last = is_last;
        send_item(row);
    endtask

    // Result side: random ready gaps, then check each transaction in order.
    initial begin
        int           gap;
        norm_result_t want;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 99) == 0) receiver_burst = !receiver_burst;
            gap = draw_gap(receiver_burst);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            if (norms_due.size() == 0) begin
                report_mismatch("unexpected norm", m_tdata, '0);
            end else begin
                want = norms_due.pop_front();
                if (m_tdata !== want.norm) report_mismatch("norm", m_tdata, want.norm);
                if (m_tuser !== want.sat) begin
                    report_mismatch("saturated", NormWidth'(m_tuser), NormWidth'(want.sat));
                end
            end
            @(negedge aclk);
        end
    end

    initial begin
        int  elems_sent;
        int  len;
        int  kind;
        bit  heavy;
        bit  close_empty;
        bit  paused;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        model_sum = '0;
        model_sat = 1'b0;
        sender_burst = 1'b0;
        elems_sent = 0;
        paused = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DirectedTable[i]) send_item(DirectedTable[i]);

        while (elems_sent < RandomItems) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                // An empty vector; the sample bits must not matter.
                send_plain($urandom, 1'b0, 1'b1);
                elems_sent++;
            end else begin
                heavy = (kind <= 3);
                len = heavy ? $urandom_range(4, 9) : $urandom_range(1, 12);
                close_empty = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0) send_plain($urandom, 1'b0, 1'b0);
                    send_plain(draw_element(heavy), 1'b1, (i == len - 1) && !close_empty);
                    elems_sent++;
                end
                if (close_empty) begin
                    send_plain($urandom, 1'b0, 1'b1);
                    elems_sent++;
                end
            end
            if (!paused && elems_sent >= RandomItems / 2) begin
                // Hold the input off until the block has drained completely.
                paused = 1'b1;
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (norms_due.size() != 0) @(negedge aclk);
            end
        end

        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (norms_due.size() != 0) @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);
        if (fail_count == 0) begin
            $display("vector_euclidean_norm regression: pass");
        end else begin
            $display("vector_euclidean_norm regression: fail");
        end
        $finish;
    end

endmodule
